// ----- rtl/qoi_enc_pkg.sv -----
package qoi_enc_pkg;

  localparam int unsigned IndexDepth = 64;
  localparam int unsigned HashW      = $clog2(IndexDepth);
  localparam int unsigned SeqLen     = 28;
  localparam int unsigned SeqW       = $clog2(SeqLen);

  // byte positions inside one emitted word sequence
  localparam int unsigned PosRun = 14;
  localparam int unsigned PosOp  = 15;
  localparam int unsigned PosEnd = 20;
  localparam int unsigned PosEos = 27;

  localparam logic [5:0]  RunMax   = 6'd62;
  localparam logic [31:0] Magic    = 32'h716F6966;
  localparam logic [7:0]  OpRgb    = 8'hFE;
  localparam logic [7:0]  OpRgba   = 8'hFF;
  localparam logic [1:0]  TagIndex = 2'b00;
  localparam logic [1:0]  TagDiff  = 2'b01;
  localparam logic [1:0]  TagLuma  = 2'b10;
  localparam logic [1:0]  TagRun   = 2'b11;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_ALPHA  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_stream;
  } byte_out_t;

  function automatic logic [HashW-1:0] color_hash(input logic [31:0] px);
    logic [HashW-1:0] r3, g5, b7, a11;
    r3  = HashW'(px[31:24]) * HashW'(3);
    g5  = HashW'(px[23:16]) * HashW'(5);
    b7  = HashW'(px[15:8]) * HashW'(7);
    a11 = HashW'(px[7:0]) * HashW'(11);
    return r3 + g5 + b7 + a11;
  endfunction

endpackage

// ----- rtl/qoi_image_encoder_top.sv -----
// QOI stream encoder. Each accepted pixel word is hashed and its color index entry is read
// from a 64 x 32 synchronous memory into a register; the encode stage then codes the pixel
// against that entry and the previous pixel, writes the entry back and loads the bytes into
// an output sequencer that hands out one byte word per cycle while out_ready is high. Pixels
// that continue a run or become single-byte ops stream back to back while out_ready is high;
// a pixel with more bytes holds the next until all but its last are out; the first pixel adds
// the 14-byte header, the last a pending run byte and the 8-byte end marker. The output byte
// rate of the sequencer sets the throughput. A read of an index entry written by the pixel
// just before is forwarded, so equal hashes in a row need no stall. After the last pixel
// all state is back at its reset value; the registers keep theirs and should be written
// only while no image is in flight.
module qoi_image_encoder_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  qoi_enc_pkg::pixel_in_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output qoi_enc_pkg::byte_out_t out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned IndexDepth = qoi_enc_pkg::IndexDepth;
  localparam int unsigned HashW = qoi_enc_pkg::HashW;
  localparam int unsigned SeqLen = qoi_enc_pkg::SeqLen;
  localparam int unsigned SeqW = qoi_enc_pkg::SeqW;

  // configuration
  logic [30:0] width_r, height_r;
  logic        alpha_en_r;
  qoi_enc_pkg::reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = qoi_enc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 31'd1;
      height_r   <= 31'd1;
      alpha_en_r <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        qoi_enc_pkg::REG_WIDTH:  width_r    <= pwdata[30:0];
        qoi_enc_pkg::REG_HEIGHT: height_r   <= pwdata[30:0];
        qoi_enc_pkg::REG_ALPHA:  alpha_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      qoi_enc_pkg::REG_WIDTH:  prdata = {1'b0, width_r};
      qoi_enc_pkg::REG_HEIGHT: prdata = {1'b0, height_r};
      qoi_enc_pkg::REG_ALPHA:  prdata = {31'd0, alpha_en_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // input stage and index read
  logic [31:0]      in_px;
  logic [HashW-1:0] in_hash;
  logic             in_fire;

  logic             s1_valid_r, s1_last_r;
  logic [31:0]      s1_px_r;
  logic [HashW-1:0] s1_hash_r;
  logic             s1_fire;

  logic [31:0]           idx_mem [IndexDepth];
  logic [IndexDepth-1:0] idx_vld_r;
  logic [31:0]           rd_data_r, fwd_data_r;
  logic                  rd_ok_r, fwd_sel_r;
  logic                  mem_we, clr_img;

  assign in_px   = {in_data.red, in_data.green, in_data.blue,
                    alpha_en_r ? in_data.alpha : 8'hFF};
  assign in_hash = HashW'(qoi_enc_pkg::color_hash(in_px));
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= in_px;
      s1_last_r <= in_data.last_pixel;
      s1_hash_r <= in_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      idx_mem[s1_hash_r] <= s1_px_r;
    end
    if (in_fire) begin
      rd_data_r <= idx_mem[in_hash];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_vld_r <= '0;
    end else if (clr_img) begin
      idx_vld_r <= '0;
    end else if (mem_we) begin
      idx_vld_r[s1_hash_r] <= 1'b1;
    end
  end

  // forward a write to the same entry made at the read edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r   <= 1'b0;
      fwd_sel_r <= 1'b0;
    end else if (in_fire) begin
      if (clr_img) begin
        rd_ok_r   <= 1'b0;
        fwd_sel_r <= 1'b0;
      end else if (mem_we && s1_hash_r == in_hash) begin
        rd_ok_r   <= 1'b1;
        fwd_sel_r <= 1'b1;
      end else begin
        rd_ok_r   <= idx_vld_r[in_hash];
        fwd_sel_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data_r <= s1_px_r;
    end
  end

  // encode stage
  logic [31:0] prev_r, prev_nxt, ent_px;
  logic [5:0]  run_r, run_nxt, run_inc, run_cnt;
  logic        hdr_sent_r, hdr_sent_nxt;
  logic        px_eq, run_full, run_emit, idx_hit;
  logic [7:0]  dr, dg, db, d2r, d2g, d2b, dg32, ldr, ldb;
  logic [7:0]  pr, pg, pb, pa, cr, cg, cb, ca;
  logic [2:0]  op_cnt;
  logic [4:0][7:0] op_bytes;
  logic        rec_empty, em_take;

  logic [SeqLen-1:0] em_mask_r, em_mask_nxt, load_mask;
  logic [7:0]        em_run_r;
  logic [4:0][7:0]   em_op_r;

  assign {cr, cg, cb, ca} = s1_px_r;
  assign {pr, pg, pb, pa} = prev_r;
  assign ent_px = fwd_sel_r ? fwd_data_r : (rd_ok_r ? rd_data_r : 32'd0);

  assign px_eq    = s1_px_r == prev_r;
  assign run_inc  = run_r + 6'd1;
  assign run_full = run_inc == qoi_enc_pkg::RunMax;
  assign run_cnt  = px_eq ? run_inc : run_r;
  assign run_emit = px_eq ? (run_full || s1_last_r) : (run_r != 6'd0);
  assign idx_hit  = !px_eq && ent_px == s1_px_r;

  assign dr   = cr - pr;
  assign dg   = cg - pg;
  assign db   = cb - pb;
  assign d2r  = dr + 8'd2;
  assign d2g  = dg + 8'd2;
  assign d2b  = db + 8'd2;
  assign dg32 = dg + 8'd32;
  assign ldr  = dr - dg + 8'd8;
  assign ldb  = db - dg + 8'd8;

  always_comb begin
    op_cnt   = 3'd0;
    op_bytes = '0;
    if (px_eq) begin
      op_cnt = 3'd0;
    end else if (idx_hit) begin
      op_cnt      = 3'd1;
      op_bytes[0] = {qoi_enc_pkg::TagIndex, 6'(s1_hash_r)};
    end else if (ca == pa) begin
      if (d2r < 8'd4 && d2g < 8'd4 && d2b < 8'd4) begin
        op_cnt      = 3'd1;
        op_bytes[0] = {qoi_enc_pkg::TagDiff, d2r[1:0], d2g[1:0], d2b[1:0]};
      end else if (dg32 < 8'd64 && ldr < 8'd16 && ldb < 8'd16) begin
        op_cnt      = 3'd2;
        op_bytes[0] = {qoi_enc_pkg::TagLuma, dg32[5:0]};
        op_bytes[1] = {ldr[3:0], ldb[3:0]};
      end else begin
        op_cnt   = 3'd4;
        op_bytes = {8'd0, cb, cg, cr, qoi_enc_pkg::OpRgb};
      end
    end else begin
      op_cnt   = 3'd5;
      op_bytes = {ca, cb, cg, cr, qoi_enc_pkg::OpRgba};
    end
  end

  always_comb begin
    load_mask = '0;
    for (int i = 0; i < qoi_enc_pkg::PosRun; i++) begin
      load_mask[i] = !hdr_sent_r;
    end
    load_mask[qoi_enc_pkg::PosRun] = run_emit;
    for (int i = 0; i < 5; i++) begin
      load_mask[qoi_enc_pkg::PosOp + i] = 3'(i) < op_cnt;
    end
    for (int i = qoi_enc_pkg::PosEnd; i < SeqLen; i++) begin
      load_mask[i] = s1_last_r;
    end
  end

  assign rec_empty = load_mask == '0;
  assign em_take   = ((em_mask_r & (em_mask_r - SeqLen'(1))) == '0) &&
                     (em_mask_r == '0 || out_ready);
  assign s1_fire   = s1_valid_r && (rec_empty || em_take);
  assign mem_we    = s1_fire && !px_eq && !idx_hit;
  assign clr_img   = s1_fire && s1_last_r;

  always_comb begin
    prev_nxt     = prev_r;
    run_nxt      = run_r;
    hdr_sent_nxt = hdr_sent_r;
    if (s1_fire) begin
      hdr_sent_nxt = 1'b1;
      prev_nxt     = s1_px_r;
      run_nxt      = (px_eq && !run_full) ? run_inc : 6'd0;
      if (s1_last_r) begin
        prev_nxt     = 32'h0000_00FF;
        run_nxt      = 6'd0;
        hdr_sent_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= 32'h0000_00FF;
      run_r      <= 6'd0;
      hdr_sent_r <= 1'b0;
    end else begin
      prev_r     <= prev_nxt;
      run_r      <= run_nxt;
      hdr_sent_r <= hdr_sent_nxt;
    end
  end

  // output sequencer
  logic [SeqW-1:0] sel;
  logic [7:0]      seq [SeqLen];

  always_comb begin
    em_mask_nxt = em_mask_r;
    if (out_valid && out_ready) begin
      em_mask_nxt = em_mask_r & (em_mask_r - SeqLen'(1));
    end
    if (s1_fire && !rec_empty) begin
      em_mask_nxt = load_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_mask_r <= '0;
    end else begin
      em_mask_r <= em_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !rec_empty) begin
      em_run_r <= {qoi_enc_pkg::TagRun, run_cnt - 6'd1};
      em_op_r  <= op_bytes;
    end
  end

  always_comb begin
    sel = '0;
    for (int i = SeqLen - 1; i >= 0; i--) begin
      if (em_mask_r[i]) begin
        sel = SeqW'(i);
      end
    end
  end

  always_comb begin
    seq[0]  = qoi_enc_pkg::Magic[31:24];
    seq[1]  = qoi_enc_pkg::Magic[23:16];
    seq[2]  = qoi_enc_pkg::Magic[15:8];
    seq[3]  = qoi_enc_pkg::Magic[7:0];
    seq[4]  = {1'b0, width_r[30:24]};
    seq[5]  = width_r[23:16];
    seq[6]  = width_r[15:8];
    seq[7]  = width_r[7:0];
    seq[8]  = {1'b0, height_r[30:24]};
    seq[9]  = height_r[23:16];
    seq[10] = height_r[15:8];
    seq[11] = height_r[7:0];
    seq[12] = alpha_en_r ? 8'd4 : 8'd3;
    seq[13] = 8'd0;
    seq[qoi_enc_pkg::PosRun] = em_run_r;
    for (int i = 0; i < 5; i++) begin
      seq[qoi_enc_pkg::PosOp + i] = em_op_r[i];
    end
    for (int i = qoi_enc_pkg::PosEnd; i < qoi_enc_pkg::PosEos; i++) begin
      seq[i] = 8'd0;
    end
    seq[qoi_enc_pkg::PosEos] = 8'd1;
  end

  assign out_valid              = em_mask_r != '0;
  assign out_data.out_byte      = seq[sel];
  assign out_data.end_of_stream = sel == SeqW'(qoi_enc_pkg::PosEos);

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && s1_valid_r && !s1_fire))
    else $error("input taken while encode stage holds");

  a_eos_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_stream) |->
      em_mask_r == (SeqLen'(1) << qoi_enc_pkg::PosEos))
    else $error("end marker byte not last in sequence");

  a_image_reset: assert property (@(posedge clk) disable iff (!rst_n)
    clr_img |=> (!hdr_sent_r && run_r == 6'd0 && idx_vld_r == '0))
    else $error("state not cleared after last pixel");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && px_eq) |=> run_r < qoi_enc_pkg::RunMax)
    else $error("run counter overflow");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !rec_empty && em_mask_r != '0) |->
      (out_ready && $countones(em_mask_r) == 1))
    else $error("sequencer overwritten with bytes pending");
`endif

endmodule
